/* hdl/bpbs_pkg.sv */
// Shared types and constants for the bitonic peak search block.
// No dependencies; every other file imports this package.
package bpbs_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int DATA_W      = 32;

  // Read address source for the sample memory.
  typedef enum logic [2:0] {
    RD_LO     = 3'd0,
    RD_HI     = 3'd1,
    RD_MID    = 3'd2,
    RD_MID_P1 = 3'd3,
    RD_MID_M1 = 3'd4
  } rd_sel_t;

  // Source of the result register.
  typedef enum logic [1:0] {
    RES_DATA = 2'd0,
    RES_MAX  = 2'd1,
    RES_MID  = 2'd2
  } res_sel_t;

  typedef struct packed {
    logic     store;      // write the accepted item into the memory
    logic     start;      // open the search window over the stored items
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     mid_load;
    logic     cap_a;
    logic     cap_b;
    logic     res_load;
    res_sel_t res_sel;
    logic     go_left;
    logic     go_right;
    logic     out_load;
    logic     clear_seq;
  } bpbs_cmd_t;

  typedef struct packed {
    logic lo_eq_hi;
    logic lo_next_hi;
    logic m_gt_nx;
    logic m_gt_pv;
    logic pv_gt_m;
  } bpbs_stat_t;

endpackage

/* hdl/bpbs_if.sv */
// Valid/ready stream interfaces for the input and result channels.
// Depends on bpbs_pkg for the data width.
interface bpbs_in_if
  import bpbs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic signed [DATA_W-1:0] sample_value;
  logic              last_item;

  modport source (output valid, output sample_value, output last_item, input ready);
  modport sink   (input valid, input sample_value, input last_item, output ready);
endinterface

interface bpbs_out_if
  import bpbs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic signed [DATA_W-1:0] peak_value;
  logic              truncated;

  modport source (output valid, output peak_value, output truncated, input ready);
  modport sink   (input valid, input peak_value, input truncated, output ready);
endinterface

/* hdl/bitonic_peak_binary_search_top.sv */
// Top level of the bitonic peak search block.
// Depends on bpbs_pkg, bpbs_if, bpbs_ctrl and bpbs_dp.
//
//   Channel  Dir  Payload                      Item
//   in_ch    in   sample_value[31:0], last_item  one element of the sequence
//   out_ch   out  peak_value[31:0], truncated    one peak per sequence
//
// Loading accepts one item per cycle; in_ch is ready in every loading cycle,
// even while a previous result still waits in the output register.
// The item marked last starts the search. Each halving step passes through
// S_EVAL, S_MID_A, S_MID_B and S_MID_C (window check plus three reads of the
// single memory read port, then the compare), and the final window of one or
// two entries goes through S_ONE or through S_TWO_A and S_TWO_B before the
// result is registered. During the search in_ch is not ready.
// Reset is synchronous and clears the fill count, window and control state;
// the memory is not cleared, since every entry is written before it is read.
module bitonic_peak_binary_search_top
  import bpbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  bpbs_in_if.sink           in_ch,
  bpbs_out_if.source        out_ch
);

  bpbs_cmd_t  cmd;
  bpbs_stat_t stat;

  // The controller sequences memory reads and window moves; the datapath
  // holds the memory and makes the signed compares it reports back.
  bpbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_item),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bpbs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sample_value (in_ch.sample_value),
    .stat         (stat),
    .peak_value   (out_ch.peak_value),
    .truncated    (out_ch.truncated)
  );

endmodule

/* hdl/bpbs_dp.sv */
// Datapath: sample memory, fill count, search window and result registers.
// Depends on bpbs_pkg; driven by commands from bpbs_ctrl.
module bpbs_dp
  import bpbs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  bpbs_cmd_t                cmd,
  input  logic signed [DATA_W-1:0] sample_value,
  output bpbs_stat_t               stat,
  output logic signed [DATA_W-1:0] peak_value,
  output logic                     truncated
);

  logic signed [DATA_W-1:0] mem [STORE_DEPTH];
  logic signed [DATA_W-1:0] rd_data;
  logic signed [DATA_W-1:0] val_a;
  logic signed [DATA_W-1:0] val_b;
  logic signed [DATA_W-1:0] res;
  logic [CNT_W-1:0]  fill;
  logic              overflow;
  logic [ADDR_W-1:0] lo;
  logic [ADDR_W-1:0] hi;
  logic [ADDR_W-1:0] mid;
  logic [ADDR_W-1:0] mid_comb;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  sum;
  logic              room;

  assign room     = fill < CNT_W'(STORE_DEPTH);
  assign sum      = {1'b0, lo} + {1'b0, hi};
  assign mid_comb = sum[CNT_W-1:1];

  always_comb begin
    unique case (cmd.rd_sel)
      RD_LO:     rd_addr = lo;
      RD_HI:     rd_addr = hi;
      RD_MID:    rd_addr = mid_comb;
      RD_MID_P1: rd_addr = mid + ADDR_W'(1);
      RD_MID_M1: rd_addr = mid - ADDR_W'(1);
      default:   rd_addr = lo;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.store && room) begin
      mem[fill[ADDR_W-1:0]] <= sample_value;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      overflow <= 1'b0;
      lo       <= '0;
      hi       <= '0;
    end else begin
      if (cmd.clear_seq) begin
        fill     <= '0;
        overflow <= 1'b0;
      end else if (cmd.store) begin
        if (room) begin
          fill <= fill + CNT_W'(1);
        end else begin
          overflow <= 1'b1;
        end
      end
      if (cmd.start) begin
        lo <= '0;
        hi <= room ? fill[ADDR_W-1:0] : ADDR_W'(STORE_DEPTH - 1);
      end else if (cmd.go_left) begin
        hi <= mid - ADDR_W'(1);
      end else if (cmd.go_right) begin
        lo <= mid + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mid_load) begin
      mid <= mid_comb;
    end
    if (cmd.cap_a) begin
      val_a <= rd_data;
    end
    if (cmd.cap_b) begin
      val_b <= rd_data;
    end
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        RES_DATA: res <= rd_data;
        RES_MAX:  res <= (rd_data > val_a) ? rd_data : val_a;
        RES_MID:  res <= val_a;
        default:  res <= rd_data;
      endcase
    end
    if (cmd.out_load) begin
      peak_value <= res;
      truncated  <= overflow;
    end
  end

  // In the three-read step val_a holds mid, val_b mid+1, and rd_data mid-1.
  assign stat.lo_eq_hi   = lo == hi;
  assign stat.lo_next_hi = {1'b0, hi} == ({1'b0, lo} + CNT_W'(1));
  assign stat.m_gt_nx    = val_a > val_b;
  assign stat.m_gt_pv    = val_a > rd_data;
  assign stat.pv_gt_m    = rd_data > val_a;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(STORE_DEPTH))
    else $error("fill count exceeds memory depth");
  a_read_written: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> ({1'b0, rd_addr} < fill))
    else $error("search reads an entry past the fill count");
  a_right_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.go_right |=> (lo > $past(lo)) && (lo <= hi))
    else $error("right move did not shrink the window");
  a_left_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.go_left |=> (hi < $past(hi)) && (lo <= hi))
    else $error("left move did not shrink the window");
`endif

endmodule

/* hdl/bpbs_ctrl.sv */
// Controller state machine: loading, search sequencing and result handoff.
// Depends on bpbs_pkg; drives bpbs_dp through the command struct.
module bpbs_ctrl
  import bpbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_last,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  bpbs_stat_t stat,
  output bpbs_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_EVAL  = 9'b000000010,
    S_ONE   = 9'b000000100,
    S_TWO_A = 9'b000001000,
    S_TWO_B = 9'b000010000,
    S_MID_A = 9'b000100000,
    S_MID_B = 9'b001000000,
    S_MID_C = 9'b010000000,
    S_PUT   = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_LO;
    cmd.res_sel = RES_DATA;
    in_ready   = 1'b0;
    unique case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.store = 1'b1;
          if (in_last) begin
            cmd.start  = 1'b1;
            state_next = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        cmd.rd_en = 1'b1;
        if (stat.lo_eq_hi) begin
          cmd.rd_sel = RD_LO;
          state_next = S_ONE;
        end else if (stat.lo_next_hi) begin
          cmd.rd_sel = RD_LO;
          state_next = S_TWO_A;
        end else begin
          cmd.rd_sel   = RD_MID;
          cmd.mid_load = 1'b1;
          state_next   = S_MID_A;
        end
      end
      S_ONE: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_DATA;
        state_next   = S_PUT;
      end
      S_TWO_A: begin
        cmd.cap_a  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_HI;
        state_next = S_TWO_B;
      end
      S_TWO_B: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_MAX;
        state_next   = S_PUT;
      end
      S_MID_A: begin
        cmd.cap_a  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_MID_P1;
        state_next = S_MID_B;
      end
      S_MID_B: begin
        cmd.cap_b  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_MID_M1;
        state_next = S_MID_C;
      end
      S_MID_C: begin
        priority if (stat.m_gt_nx && stat.m_gt_pv) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_MID;
          state_next   = S_PUT;
        end else if (stat.m_gt_nx && stat.pv_gt_m) begin
          cmd.go_left = 1'b1;
          state_next  = S_EVAL;
        end else begin
          cmd.go_right = 1'b1;
          state_next   = S_EVAL;
        end
      end
      S_PUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load  = 1'b1;
          cmd.clear_seq = 1'b1;
          state_next    = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_rise_from_put: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_PUT))
    else $error("result appeared outside the handoff state");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register loaded while a result is pending");
  a_start_is_last: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> state == S_EVAL)
    else $error("search did not begin after the last item");
`endif

endmodule

/* tb/bitonic_peak_binary_search_top_tb.sv */
// Testbench for bitonic_peak_binary_search_top: drives sequences of samples, predicts
// each peak with an independent binary search, and checks every result item.
// Depends on bpbs_pkg, bpbs_if and the top level with its submodules.
module bitonic_peak_binary_search_top_tb;
  import bpbs_pkg::*;

  typedef logic signed [DATA_W-1:0] sample_t;

  // One expected result item: the peak and whether the sequence overflowed the store.
  typedef struct {
    sample_t peak;
    logic    trunc;
  } peak_result_t;

  // One row of the directed table. When has_peak is set, the expected result is
  // the typed one; otherwise the predictor supplies it.
  typedef struct packed {
    sample_t v;
    logic    last;
    logic    has_peak;
    sample_t peak;
    logic    trunc;
  } dir_row_t;

  localparam sample_t S_MIN = 32'sh8000_0000;
  localparam sample_t S_MAX = 32'sh7fff_ffff;
  localparam int      N_DIR = 27;
  localparam int      N_RANDOM = 1500;
  // Settle time after the last result, longer than twice the longest search.
  localparam int      SETTLE_CYCLES = 120;
  localparam int      LIMIT_CYCLES = 1000000;

  logic clk;
  logic rst;

  bpbs_in_if  in_ch();
  bpbs_out_if out_ch();

  bitonic_peak_binary_search_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 20-unit clock period: high for 10, low for 10.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Independent end of the run in case the handshakes stop moving.
  initial begin
    #(LIMIT_CYCLES * 20);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Peak predictor. It mirrors the block's own state: the samples stored in the
  // current sequence and a flag for samples dropped because the store was full.
  // ---------------------------------------------------------------------------
  sample_t      stored_samples[$];
  logic         overflow_seen;
  peak_result_t pending_peaks[$];

  // A typed expectation from the directed table overrides the predicted one.
  logic         use_typed;
  peak_result_t typed_peak;

  int           error_count;

  // Binary peak search over the stored samples, with the same decisions as the
  // block: a window of one or two returns the larger (the first on a tie), a
  // middle above both neighbours is the answer, a middle above the next and
  // below the previous moves left, and everything else moves right.
  function automatic sample_t search_peak();
    int      lo;
    int      hi;
    int      mid;
    bit      done;
    sample_t found;
    lo    = 0;
    hi    = stored_samples.size() - 1;
    done  = 1'b0;
    found = '0;
    while (!done) begin
      if (lo == hi) begin
        found = stored_samples[lo];
        done  = 1'b1;
      end else if (hi == lo + 1) begin
        found = (stored_samples[hi] > stored_samples[lo]) ? stored_samples[hi]
                                                          : stored_samples[lo];
        done  = 1'b1;
      end else begin
        mid = (lo + hi) / 2;
        if (stored_samples[mid] > stored_samples[mid + 1] &&
            stored_samples[mid] > stored_samples[mid - 1]) begin
          found = stored_samples[mid];
          done  = 1'b1;
        end else if (stored_samples[mid] > stored_samples[mid + 1] &&
                     stored_samples[mid - 1] > stored_samples[mid]) begin
          hi = mid - 1;
        end else begin
          lo = mid + 1;
        end
      end
    end
    return found;
  endfunction

  // Called once per accepted input item. A full store drops the item, the last
  // one included, and marks the sequence as truncated.
  task automatic record_sample(input sample_t v, input logic is_last);
    peak_result_t r;
    if (stored_samples.size() < STORE_DEPTH) begin
      stored_samples.push_back(v);
    end else begin
      overflow_seen = 1'b1;
    end
    if (is_last) begin
      r.peak  = search_peak();
      r.trunc = overflow_seen;
      if (use_typed) begin
        r = typed_peak;
      end
      pending_peaks.push_back(r);
      stored_samples.delete();
      overflow_seen = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    error_count++;
    if (error_count <= 40) begin
      $display("mismatch at %0t: %s, expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result item is compared with the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------------
  peak_result_t oldest_peak;

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_peaks.size() == 0) begin
        report_mismatch("result with nothing expected", '0, out_ch.peak_value);
      end else begin
        oldest_peak = pending_peaks.pop_front();
        if (out_ch.peak_value !== oldest_peak.peak) begin
          report_mismatch("peak_value", oldest_peak.peak, out_ch.peak_value);
        end
        if (out_ch.truncated !== oldest_peak.trunc) begin
          report_mismatch("truncated", {31'd0, oldest_peak.trunc}, {31'd0, out_ch.truncated});
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver. It switches between three stall patterns:
  // always ready, ready at random with odds of three in four, or long stalls broken by
  // short ready windows. The long stalls let results back up behind a search.
  // ---------------------------------------------------------------------------
  int rx_cycle;
  int rx_mode;
  int rx_hold;

  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 300 == 0) begin
      rx_mode = $urandom_range(0, 2);
    end
    case (rx_mode)
      0: out_ch.ready = 1'b1;
      1: out_ch.ready = ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          out_ch.ready = 1'b0;
        end else begin
          rx_hold = $urandom_range(1, 40);
          out_ch.ready = 1'b1;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sender. Items go out in bursts of random length with random gaps between
  // them, unless the current sequence is marked steady. Inputs change only at
  // the falling edge; acceptance is sampled at the rising edge.
  // ---------------------------------------------------------------------------
  int burst_left;
  bit sender_steady;

  task automatic send_sample(input sample_t v, input logic is_last);
    int gap;
    if (!sender_steady && burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      burst_left = $urandom_range(1, 24);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    in_ch.valid        = 1'b1;
    in_ch.sample_value = v;
    in_ch.last_item    = is_last;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    record_sample(v, is_last);
    @(negedge clk);
  endtask

  // Holds the input idle until every expected result has come back.
  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (pending_peaks.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence builder. Most kinds rise to a random peak and then fall, with step
  // sizes anywhere from one to a large fraction of the range; values clamp at
  // the signed extremes, which also yields plateaus there. Other kinds are
  // monotonic runs, runs with flat steps, and plain noise.
  // ---------------------------------------------------------------------------
  sample_t seq_samples[$];

  function automatic sample_t clamp32(input longint x);
    if (x > longint'(S_MAX)) begin
      return S_MAX;
    end
    if (x < longint'(S_MIN)) begin
      return S_MIN;
    end
    return sample_t'(x);
  endfunction

  task automatic build_sequence(input int kind, input int len);
    int     peak_at;
    int     step_bits;
    longint cur;
    longint step;
    seq_samples.delete();
    case (kind)
      7:       peak_at = len - 1;
      8:       peak_at = 0;
      default: peak_at = $urandom_range(0, len - 1);
    endcase
    step_bits = $urandom_range(0, 28);
    cur = longint'($signed($urandom));
    for (int i = 0; i < len; i++) begin
      if (kind == 9) begin
        cur = longint'($signed($urandom));
      end else if (i > 0) begin
        step = longint'($urandom & ((32'd1 << step_bits) - 1));
        if (kind != 6) begin
          step = step + 1;
        end
        cur = (i <= peak_at) ? cur + step : cur - step;
      end
      seq_samples.push_back(clamp32(cur));
      cur = longint'(seq_samples[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table: single-item sequences at both extremes, two-item windows
  // with ties and with either side larger, a short bitonic run, monotonic runs
  // both ways, a plateau, and a sequence that is not bitonic at all.
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows [0:N_DIR-1] = '{
    '{S_MIN, 1'b1, 1'b1, S_MIN, 1'b0},
    '{S_MAX, 1'b1, 1'b1, S_MAX, 1'b0},
    '{32'sd0, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{32'sd0, 1'b1, 1'b1, 32'sd0, 1'b0},
    '{32'sd3, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{32'sd7, 1'b1, 1'b1, 32'sd7, 1'b0},
    '{S_MAX, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{S_MIN, 1'b1, 1'b1, S_MAX, 1'b0},
    '{32'sd1, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{32'sd5, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{32'sd9, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{32'sd4, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{32'sd2, 1'b1, 1'b0, 32'sd0, 1'b0},
    '{S_MIN, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{-32'sd1, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{32'sd0, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{S_MAX, 1'b1, 1'b0, 32'sd0, 1'b0},
    '{32'sd10, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{32'sd0, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{-32'sd10, 1'b1, 1'b0, 32'sd0, 1'b0},
    '{32'sd3, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{32'sd3, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{32'sd3, 1'b1, 1'b0, 32'sd0, 1'b0},
    '{32'sd5, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{32'sd1, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{32'sd5, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{-32'sd9, 1'b1, 1'b0, 32'sd0, 1'b0}
  };

  // ---------------------------------------------------------------------------
  // Main stimulus.
  // ---------------------------------------------------------------------------
  int random_items;
  int seq_len;
  int seq_kind;

  initial begin
    // Every input known from time zero; reset held asserted at the start.
    rst                = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.sample_value = '0;
    in_ch.last_item    = 1'b0;
    out_ch.ready       = 1'b0;
    overflow_seen      = 1'b0;
    use_typed          = 1'b0;
    error_count        = 0;
    burst_left         = 0;
    sender_steady      = 1'b0;
    rx_cycle           = 0;
    rx_mode            = 1;
    rx_hold            = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows. Typed expectations go straight into the result queue.
    for (int i = 0; i < N_DIR; i++) begin
      use_typed        = dir_rows[i].has_peak;
      typed_peak.peak  = dir_rows[i].peak;
      typed_peak.trunc = dir_rows[i].trunc;
      send_sample(dir_rows[i].v, dir_rows[i].last);
    end
    use_typed = 1'b0;
    drain_results();

    // A sequence that fills the store exactly, so the search spans every
    // entry and nothing is truncated.
    sender_steady = 1'b1;
    build_sequence(0, STORE_DEPTH);
    for (int i = 0; i < STORE_DEPTH; i++) begin
      send_sample(seq_samples[i], i == STORE_DEPTH - 1);
    end

    // Two items past the depth: the extra one and the last item are dropped,
    // the search runs over the full store and the result is flagged.
    sender_steady = 1'b0;
    build_sequence(3, STORE_DEPTH + 2);
    for (int i = 0; i < STORE_DEPTH + 2; i++) begin
      send_sample(seq_samples[i], i == STORE_DEPTH + 1);
    end
    drain_results();

    // Random sequences, mostly short and well formed. Now and then one runs
    // to a few hundred items, and now and then the sender waits for every
    // pending result before going on.
    random_items = 0;
    while (random_items < N_RANDOM) begin
      seq_kind      = $urandom_range(0, 9);
      seq_len       = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 400)
                                                   : $urandom_range(1, 24);
      sender_steady = ($urandom_range(0, 3) == 0);
      build_sequence(seq_kind, seq_len);
      for (int i = 0; i < seq_len; i++) begin
        send_sample(seq_samples[i], i == seq_len - 1);
      end
      random_items += seq_len;
      if ($urandom_range(0, 15) == 0) begin
        drain_results();
      end
    end

    // Wait out the last results, then give the block time to show any extra.
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/bpbs_pkg.sv
hdl/bpbs_if.sv
hdl/bpbs_dp.sv
hdl/bpbs_ctrl.sv
hdl/bitonic_peak_binary_search_top.sv
tb/bitonic_peak_binary_search_top_tb.sv
